FILE: sv/awfe_pkg.sv
// Shared types, constants and the window coefficient function of the ADC window front end.
package awfe_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CentredW = 13;
  localparam int unsigned WinW = 16;
  localparam int unsigned CoefW = 16;
  localparam real TwoPi = 6.283185307179586;

  typedef struct packed {
    logic signed [CentredW-1:0] centred;
    logic signed [WinW-1:0]     scaled;
    logic                       clipped;
    logic                       last;
  } awfe_beat_t;

  // Hann coefficient for table entry idx, with step the angle between entries.
  function automatic logic [CoefW-1:0] hann_coef(input int unsigned idx, input real step);
    real c;
    real v;
    int  h;
    c = $cos(step * real'(idx));
    v = 16384.0 * (1.0 - c);
    if (v > 32767.0) begin
      v = 32767.0;
    end
    if (v < 0.0) begin
      v = 0.0;
    end
    h = int'(v);
    return CoefW'(h);
  endfunction

endpackage

FILE: sv/awfe_rom.sv
// Generic read-only table with a registered read port.
module awfe_rom #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter logic [WIDTH-1:0] CONTENT [DEPTH] = '{default: '0}
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= CONTENT[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/awfe_front.sv
// Input stage: DC removal, scaling with saturation, small-sample gating and block counter.
module awfe_front import awfe_pkg::*; #(
  parameter int unsigned BLOCK_SIZE = 1024,
  parameter int unsigned ADC_BITS   = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [SampleW-1:0]            cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic [SampleW-1:0]            in_sample_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output awfe_beat_t                    out_beat_o,
  output logic                          rd_en_o,
  output logic [$clog2(BLOCK_SIZE)-1:0] rd_addr_o
);

  localparam int unsigned IdxW = $clog2(BLOCK_SIZE);
  localparam int unsigned DcW = (ADC_BITS > SampleW) ? ADC_BITS : SampleW;
  localparam int unsigned CenW = DcW + 1;
  localparam logic [SampleW-1:0] AdcMask = SampleW'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [DcW-1:0] DcReset = DcW'(64'd1 << (ADC_BITS - 1));
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BLOCK_SIZE - 1);

  logic [DcW-1:0]         dc_q;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   valid_q;
  awfe_beat_t             beat_q, beat_d;
  logic                   accept;
  logic signed [CenW-1:0] cen;
  logic                   clip_d;
  logic                   small_d;

  assign in_ready_o = ~valid_q | out_ready_i;
  assign accept = in_valid_i & in_ready_o;

  assign cen = $signed({1'b0, DcW'(in_sample_i & AdcMask)}) - $signed({1'b0, dc_q});
  assign clip_d = ~((&cen[CenW-1:8]) | (~|cen[CenW-1:8]));
  assign small_d = (cen == '0) || (cen == CenW'(1)) || (cen == '1);

  always_comb begin
    beat_d.centred = cen[CentredW-1:0];
    beat_d.clipped = clip_d;
    beat_d.last    = (idx_q == LastIdx);
    if (small_d) begin
      beat_d.scaled = '0;
    end else if (clip_d) begin
      beat_d.scaled = cen[CenW-1] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      beat_d.scaled = {cen[8:0], 7'b0};
    end
  end

  assign idx_d = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= DcReset;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dc_q <= DcW'(cfg_wdata_i);
      end
      if (accept) begin
        idx_q <= idx_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= beat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o = beat_q;
  assign rd_en_o = accept;
  assign rd_addr_o = idx_q;

  // The block counter wraps to the first entry after the final sample.
  a_idx_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && idx_q == LastIdx |=> idx_q == '0)
    else $error("block counter did not wrap");

  // Samples within one code of the midpoint carry no signal.
  a_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && small_d |=> beat_q.scaled == '0 && !beat_q.clipped)
    else $error("small sample not forced to zero");

  // A clipped sample sits at one end of the 16-bit range.
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && beat_q.clipped |-> beat_q.scaled == 16'sh7FFF || beat_q.scaled == 16'sh8000)
    else $error("clipped sample not saturated");

endmodule

FILE: sv/awfe_weight.sv
// Window stage: coefficient product, blend with the unwindowed sample and output register.
module awfe_weight import awfe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  awfe_beat_t                 in_beat_i,
  input  logic [CoefW-1:0]           coef_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [CentredW-1:0] out_centred_o,
  output logic signed [WinW-1:0]     out_win_o,
  output logic                       out_clipped_o,
  output logic                       out_last_o
);

  localparam logic [18:0] Div5Recip = 19'd419431;

  // Division by five truncating toward zero, exact for magnitudes below 2^18.
  function automatic logic signed [18:0] div5(input logic signed [18:0] v);
    logic [17:0] mag;
    logic [36:0] prod;
    logic [18:0] quo;
    mag = v[18] ? 18'(-v) : 18'(v);
    prod = 37'(mag) * 37'(Div5Recip);
    quo = 19'(prod >> 21);
    return v[18] ? -$signed(quo) : $signed(quo);
  endfunction

  logic                       v2_q, v3_q;
  logic                       rdy3;
  logic signed [32:0]         prod_d;
  logic signed [31:0]         prod_q;
  logic signed [18:0]         orig_full;
  logic signed [13:0]         orig_q;
  logic signed [CentredW-1:0] cen2_q;
  logic                       clip2_q, last2_q;
  logic signed [16:0]         hann;
  logic signed [18:0]         sum;
  logic signed [18:0]         quo;
  logic signed [WinW-1:0]     win_d, win_q;
  logic signed [CentredW-1:0] cen3_q;
  logic                       clip3_q, last3_q;

  assign rdy3 = ~v3_q | out_ready_i;
  assign in_ready_o = ~v2_q | rdy3;

  assign prod_d = in_beat_i.scaled * $signed({1'b0, coef_i});
  assign orig_full = div5(19'(in_beat_i.scaled));

  assign hann = prod_q[31:15];
  assign sum = $signed({hann, 2'b00}) + 19'(orig_q);
  assign quo = div5(sum);

  always_comb begin
    if (quo > 19'sd32767) begin
      win_d = 16'sh7FFF;
    end else if (quo < -19'sd32768) begin
      win_d = 16'sh8000;
    end else begin
      win_d = quo[WinW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q  <= prod_d[31:0];
      orig_q  <= orig_full[13:0];
      cen2_q  <= in_beat_i.centred;
      clip2_q <= in_beat_i.clipped;
      last2_q <= in_beat_i.last;
    end
    if (rdy3 && v2_q) begin
      win_q   <= win_d;
      cen3_q  <= cen2_q;
      clip3_q <= clip2_q;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_centred_o = cen3_q;
  assign out_win_o = win_q;
  assign out_clipped_o = clip3_q;
  assign out_last_o = last3_q;

  // A blend of a non-negative windowed part and a non-negative unwindowed part stays non-negative.
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && rdy3 && !prod_q[31] && !orig_q[13] |=> !win_q[WinW-1])
    else $error("windowed sample changed sign");

  // Nothing in, nothing out: a zero product and a zero sample give zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && rdy3 && prod_q[31:15] == '0 && orig_q == '0 |=> win_q == '0)
    else $error("zero input produced a nonzero window result");

endmodule

FILE: sv/adc_window_front_end_unit.sv
// Top level of the ADC window front end: ports, window table and stage wiring.
// Each beat carries one 12-bit converter sample; the block removes the DC midpoint, scales
// by 128 with saturation, zeroes samples within one code of the midpoint and blends four
// fifths of the Hann-windowed sample with one twenty-fifth of the unwindowed sample. One
// beat is taken every cycle while the master side does not stall. DC removal and scaling
// are registered together with the window table read when a beat is accepted, then the
// coefficient multiply is registered, and last the blend with division by five goes into
// the output register. The window table is a BLOCK_SIZE by 16-bit ROM built at
// elaboration, and tlast marks the final sample of each block.
module adc_window_front_end_unit import awfe_pkg::*; #(
  parameter int unsigned BLOCK_SIZE = 1024,
  parameter int unsigned ADC_BITS   = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [11:0] adc_sample
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [12:0] centred_sample, [28:13] windowed_sample
  output logic               m_axis_tuser,   // [0] input_clipped
  output logic               m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(BLOCK_SIZE);
  localparam real AngleStep = TwoPi / real'(BLOCK_SIZE - 1);

  typedef logic [CoefW-1:0] coef_tab_t [BLOCK_SIZE];

  function automatic coef_tab_t build_tab();
    coef_tab_t tab;
    for (int unsigned i = 0; i < BLOCK_SIZE; i++) begin
      tab[i] = hann_coef(i, AngleStep);
    end
    return tab;
  endfunction

  localparam coef_tab_t WinTab = build_tab();

  awfe_beat_t                 front_beat;
  logic                       front_valid;
  logic                       weight_ready;
  logic                       rd_en;
  logic [IdxW-1:0]            rd_addr;
  logic [CoefW-1:0]           coef;
  logic signed [CentredW-1:0] out_centred;
  logic signed [WinW-1:0]     out_win;

  awfe_front #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .ADC_BITS  (ADC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_sample_i(s_axis_tdata[SampleW-1:0]),
    .in_ready_o (s_axis_tready),
    .out_valid_o(front_valid),
    .out_ready_i(weight_ready),
    .out_beat_o (front_beat),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  awfe_rom #(
    .WIDTH  (CoefW),
    .DEPTH  (BLOCK_SIZE),
    .CONTENT(WinTab)
  ) u_win_rom (
    .clk_i  (clk_i),
    .en_i   (rd_en),
    .addr_i (rd_addr),
    .rdata_o(coef)
  );

  awfe_weight u_weight (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (front_valid),
    .in_ready_o   (weight_ready),
    .in_beat_i    (front_beat),
    .coef_i       (coef),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_centred_o(out_centred),
    .out_win_o    (out_win),
    .out_clipped_o(m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_win, out_centred};

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the ADC window front end, with a cycle-free predictor.
`timescale 1ns / 1ps

module testbench;
  import awfe_pkg::*;

  localparam int unsigned BlockLen = 1024;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseBeats = 138;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned NumDirected = 15;

  typedef struct packed {
    logic [SampleW-1:0]         adc;
    logic                       typed;
    logic signed [CentredW-1:0] centred;
    logic signed [WinW-1:0]     scaled;
    logic                       clipped;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [SampleW-1:0] cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  int                 hann_rom [BlockLen];
  logic [SampleW-1:0] model_midpoint;
  int unsigned        model_index;
  awfe_beat_t         expected_beats [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int n_errors = 0;
  int n_samples = 0;
  int n_checked = 0;
  int n_blocks = 0;
  int idle_cycles = 0;

  dir_row_t dir_rows [NumDirected] = '{
    '{12'd2048, 1'b1, 13'sd0, 16'sd0, 1'b0},
    '{12'd2049, 1'b1, 13'sd1, 16'sd0, 1'b0},
    '{12'd2047, 1'b1, -13'sd1, 16'sd0, 1'b0},
    '{12'd2050, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd2046, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd0, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd4095, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd2303, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd2304, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd1792, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd1791, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'hAAA, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'h555, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd1, 1'b0, 13'sd0, 16'sd0, 1'b0},
    '{12'd4094, 1'b0, 13'sd0, 16'sd0, 1'b0}
  };

  adc_window_front_end_unit #(
    .BLOCK_SIZE(BlockLen),
    .ADC_BITS  (SampleW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Works out the result beat for one accepted sample and advances the block position.
  function automatic awfe_beat_t predict_window_beat(input logic [SampleW-1:0] adc);
    longint centred;
    longint wide;
    longint scaled;
    longint hann;
    longint orig;
    longint blend;
    awfe_beat_t beat;
    centred = longint'(adc) - longint'(model_midpoint);
    wide = centred * 128;
    scaled = clamp_q15(wide);
    beat.clipped = (wide != scaled);
    if (centred >= -1 && centred <= 1) begin
      scaled = 0;
    end
    hann = (scaled * longint'(hann_rom[model_index])) >>> 15;
    orig = scaled / 5;
    blend = clamp_q15((hann * 4 + orig) / 5);
    beat.centred = centred[CentredW-1:0];
    beat.scaled = blend[WinW-1:0];
    beat.last = (model_index == BlockLen - 1);
    model_index = beat.last ? 0 : model_index + 1;
    return beat;
  endfunction

  task automatic send_sample(input logic [SampleW-1:0] adc);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 16'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, adc};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    n_samples++;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      6: v = int'(model_midpoint) + $urandom_range(6) - 3;
      7: v = int'(model_midpoint) + ($urandom_range(1) ? 256 : -257) + $urandom_range(4) - 2;
      8: v = $urandom_range(1) ? 4095 : 0;
      default: v = $urandom_range(4095);
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > 4095) begin
      v = 4095;
    end
    return v[SampleW-1:0];
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    awfe_beat_t got;
    awfe_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.centred = m_axis_tdata[12:0];
      got.scaled = m_axis_tdata[28:13];
      got.clipped = m_axis_tuser;
      got.last = m_axis_tlast;
      if (got.last) begin
        n_blocks++;
      end
      if (expected_beats.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat centred=%0d windowed=%0d clip=%0b last=%0b", $time,
                 got.centred, got.scaled, got.clipped, got.last);
      end else begin
        want = expected_beats.pop_front();
        n_checked++;
        if (got !== want) begin
          n_errors++;
          $display("%0t: mismatch expected centred=%0d windowed=%0d clip=%0b last=%0b",
                   $time, want.centred, want.scaled, want.clipped, want.last);
          $display("%0t:          actual   centred=%0d windowed=%0d clip=%0b last=%0b",
                   $time, got.centred, got.scaled, got.clipped, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    awfe_beat_t beat;
    logic [SampleW-1:0] mid;
    for (int i = 0; i < BlockLen; i++) begin
      real v;
      v = 16384.0 * (1.0 - $cos(2.0 * 3.141592653589793 * real'(i) / real'(BlockLen - 1)));
      hann_rom[i] = (v + 0.5 > 32767.0) ? 32767 : $rtoi(v + 0.5);
    end
    model_midpoint = 12'd2048;
    model_index = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      beat = predict_window_beat(dir_rows[r].adc);
      if (dir_rows[r].typed) begin
        beat.centred = dir_rows[r].centred;
        beat.scaled = dir_rows[r].scaled;
        beat.clipped = dir_rows[r].clipped;
        beat.last = 1'b0;
      end
      expected_beats.push_back(beat);
      send_sample(dir_rows[r].adc);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      case (ph)
        0: mid = 12'd0;
        1: mid = 12'd4095;
        default: mid = $urandom_range(4095);
      endcase
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 68;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 68;
        end
        default: begin
          src_idle_pct = 21;
          snk_stall_pct = 21;
        end
      endcase
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= mid;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      model_midpoint = mid;
      for (int n = 0; n < PhaseBeats; n++) begin
        logic [SampleW-1:0] adc;
        adc = pick_sample();
        expected_beats.push_back(predict_window_beat(adc));
        send_sample(adc);
      end
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Summary: %0d samples sent, %0d results checked, %0d block ends seen.",
             n_samples, n_checked, n_blocks);
    $display("Summary: %0d midpoint settings including both extremes, four idle mixes.",
             NumPhases + 1);
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: adc_window_front_end_unit.f
sv/awfe_pkg.sv
sv/awfe_rom.sv
sv/awfe_front.sv
sv/awfe_weight.sv
sv/adc_window_front_end_unit.sv
bench/testbench.sv
